### rtl/core/assert_macros.svh
// Concurrent assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication from a trigger to a consequence
`define ASSERT_IMPL(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_IMPL(label, clk, rst, trig, cons, msg)

`endif

`endif

### rtl/core/abpf_pkg.sv
// Types, constants and palette for the attribute bitmap pixel fetch block
package abpf_pkg;

  localparam int BITMAP_BYTES = 6144;
  localparam int ATTR_BYTES   = 768;
  localparam int TOTAL_BYTES  = 6912;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // bit 1 set marks a pixel request
  localparam logic [1:0] KIND_WR_BMP     = 2'd0;
  localparam logic [1:0] KIND_WR_ATTR    = 2'd1;
  localparam logic [1:0] KIND_PIX_PAPER  = 2'd2;
  localparam logic [1:0] KIND_PIX_BORDER = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] bmp_addr;
    logic [9:0]  attr_addr;
    logic [7:0]  data;
    logic [2:0]  bit_sel;
    logic        phase;
    logic [2:0]  border;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic [31:0] palette_argb(input logic [3:0] idx);
    logic [31:0] c;
    unique case (idx)
      4'd0:  c = 32'hff000000;
      4'd1:  c = 32'hff0000c0;
      4'd2:  c = 32'hffc00000;
      4'd3:  c = 32'hffc000c0;
      4'd4:  c = 32'hff00c000;
      4'd5:  c = 32'hff00c0c0;
      4'd6:  c = 32'hffc0c000;
      4'd7:  c = 32'hffc0c0c0;
      4'd8:  c = 32'hff000000;
      4'd9:  c = 32'hff0000ff;
      4'd10: c = 32'hffff0000;
      4'd11: c = 32'hffff00ff;
      4'd12: c = 32'hff00ff00;
      4'd13: c = 32'hff00ffff;
      4'd14: c = 32'hffffff00;
      4'd15: c = 32'hffffffff;
      default: c = 32'hff000000;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/abpf_front.sv
// Front end: command accept, request classification and address generation
module abpf_front (
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [12:0]           mem_addr,
  input  logic [7:0]            mem_data,
  input  logic signed [9:0]     pix_x,
  input  logic signed [9:0]     pix_y,
  input  logic                  flash_phase,
  input  logic [2:0]            border_index,
  input  abpf_pkg::q_status_t    q_status,
  input  abpf_pkg::back_status_t back_status,
  output logic                  push,
  output abpf_pkg::q_entry_t     entry
);
  import abpf_pkg::*;

  logic       in_paper;
  logic       wr_ok;
  logic [7:0] ux;
  logic [7:0] uy;
  logic [7:0] row;

  assign busy = back_status.clearing | q_status.full;

  assign ux       = pix_x[7:0];
  assign uy       = pix_y[7:0];
  assign in_paper = !pix_x[9] && !pix_x[8] && !pix_y[9] && (pix_y[8:0] < 9'd192);
  assign wr_ok    = mem_addr < 13'(TOTAL_BYTES);
  // interleaved row: third, line in cell, cell row
  assign row      = {uy[7:6], uy[2:0], uy[5:3]};

  always_comb begin
    entry.data    = mem_data;
    entry.bit_sel = ux[2:0];
    entry.phase   = flash_phase;
    entry.border  = border_index;
    if (req_type == REQ_WRITE) begin
      entry.kind      = (mem_addr < 13'(BITMAP_BYTES)) ? KIND_WR_BMP : KIND_WR_ATTR;
      entry.bmp_addr  = mem_addr;
      entry.attr_addr = 10'(mem_addr - 13'(BITMAP_BYTES));
    end else begin
      entry.kind      = in_paper ? KIND_PIX_PAPER : KIND_PIX_BORDER;
      entry.bmp_addr  = {row, ux[7:3]};
      entry.attr_addr = {uy[7:3], ux[7:3]};
    end
  end

  // writes beyond the screen memory are taken and dropped
  assign push = start && !busy && ((req_type == REQ_PIXEL) || wr_ok);

endmodule

### rtl/core/abpf_queue.sv
// Short FIFO between the front end and the memory back end
module abpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  abpf_pkg::q_entry_t  entry_in,
  input  logic               pop,
  output abpf_pkg::q_entry_t  entry_out,
  output abpf_pkg::q_status_t status
);
  import abpf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign entry_out    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/abpf_back.sv
// Back end: screen memories, clearing pass, pixel decode and palette lookup
module abpf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  abpf_pkg::q_entry_t     head,
  input  logic                  head_valid,
  output logic                  pop,
  output abpf_pkg::back_status_t status,
  output logic                  strobe,
  output logic [31:0]           argb,
  output logic [3:0]            color_index
);
  import abpf_pkg::*;

  logic [7:0]  bmp_mem  [BITMAP_BYTES];
  logic [7:0]  attr_mem [ATTR_BYTES];

  logic        clearing;
  logic [12:0] clr_addr;

  logic [7:0]  bmp_q;
  logic [7:0]  attr_q;
  logic        s1_valid;
  logic        s1_border_px;
  logic [2:0]  s1_bit_sel;
  logic        s1_phase;
  logic [2:0]  s1_border;

  logic        pix;
  logic [2:0]  colour;
  logic [3:0]  idx;

  assign status.clearing = clearing;
  assign pop             = head_valid && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == 13'(BITMAP_BYTES - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bmp_mem[clr_addr] <= '0;
      if (clr_addr < 13'(ATTR_BYTES)) begin
        attr_mem[clr_addr[9:0]] <= '0;
      end
    end else if (pop && head.kind == KIND_WR_BMP) begin
      bmp_mem[head.bmp_addr] <= head.data;
    end else if (pop && head.kind == KIND_WR_ATTR) begin
      attr_mem[head.attr_addr] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bmp_q  <= bmp_mem[head.bmp_addr];
      attr_q <= attr_mem[head.attr_addr];
    end
    s1_border_px <= head.kind == KIND_PIX_BORDER;
    s1_bit_sel   <= head.bit_sel;
    s1_phase     <= head.phase;
    s1_border    <= head.border;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      s1_valid <= pop && head.kind[1];
      strobe   <= s1_valid;
    end
  end

  // bit 7 is the leftmost pixel
  assign pix    = bmp_q[~s1_bit_sel] ^ (attr_q[7] & s1_phase);
  assign colour = pix ? attr_q[2:0] : attr_q[5:3];
  assign idx    = s1_border_px ? {1'b0, s1_border} : {attr_q[6], colour};

  always_ff @(posedge clk) begin
    color_index <= idx;
    argb        <= palette_argb(idx);
  end

endmodule

### rtl/core/attr_bitmap_pixel_fetch_top.sv
// Top level of the attribute bitmap pixel fetch block
//
// channel   direction  transfer when      payload
// command   in         start && !busy    req_type mem_addr mem_data pix_x pix_y
//                                        flash_phase border_index
// result    out        strobe            argb color_index
//
// One command per cycle while busy is low. A pixel result passes the queue,
// the memory read registers and the output registers, which raise strobe.
// Writes give no result. After reset busy is high while the memories are cleared.
// Once the clear is done the back end drains one queue entry a cycle, so the
// queue never fills and busy stays low; results cannot be held off.
`include "assert_macros.svh"

module attr_bitmap_pixel_fetch_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [12:0]       mem_addr,
  input  logic [7:0]        mem_data,
  input  logic signed [9:0] pix_x,
  input  logic signed [9:0] pix_y,
  input  logic              flash_phase,
  input  logic [2:0]        border_index,
  output logic              strobe,
  output logic [31:0]       argb,
  output logic [3:0]        color_index
);
  import abpf_pkg::*;

  q_status_t    q_status;
  back_status_t back_status;
  q_entry_t     push_entry;
  q_entry_t     head_entry;
  logic         push;
  logic         pop;
  logic         pix_xfer;

  abpf_front u_front (
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .mem_addr     (mem_addr),
    .mem_data     (mem_data),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .flash_phase  (flash_phase),
    .border_index (border_index),
    .q_status     (q_status),
    .back_status  (back_status),
    .push         (push),
    .entry        (push_entry)
  );

  abpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (push_entry),
    .pop       (pop),
    .entry_out (head_entry),
    .status    (q_status)
  );

  abpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_entry),
    .head_valid  (!q_status.empty),
    .pop         (pop),
    .status      (back_status),
    .strobe      (strobe),
    .argb        (argb),
    .color_index (color_index)
  );

  assign pix_xfer = start && !busy && (req_type == REQ_PIXEL);

  `ASSERT_IMPL(a_quiet_in_clear, clk, rst, back_status.clearing, !strobe, "strobe in clear")
  `ASSERT_PROP(a_clear_once, clk, rst, !back_status.clearing |=> !back_status.clearing, "clear restarted")
  `ASSERT_IMPL(a_pixel_latency, clk, rst, pix_xfer, ##3 strobe, "pixel result missing")

endmodule

### tb/sv/tb_top.sv
// Testbench for attr_bitmap_pixel_fetch_top: screen writes and pixel colour lookups
`timescale 1ns / 100ps

module tb_top;
  import abpf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 1550;
  localparam int CALM_TAIL   = 250;

  class pixel_scoreboard;
    logic [7:0]  screen [0:TOTAL_BYTES-1];
    logic [31:0] palette [16];
    logic [31:0] argb_q [$];
    logic [3:0]  index_q [$];
    int errors;
    int checked;
    int writes;
    int dropped_writes;
    int pixels;
    int border_hits;

    function new();
      palette = '{32'hff000000, 32'hff0000c0, 32'hffc00000, 32'hffc000c0,
                  32'hff00c000, 32'hff00c0c0, 32'hffc0c000, 32'hffc0c0c0,
                  32'hff000000, 32'hff0000ff, 32'hffff0000, 32'hffff00ff,
                  32'hff00ff00, 32'hff00ffff, 32'hffffff00, 32'hffffffff};
      foreach (screen[i]) screen[i] = 8'h00;
      errors = 0;
      checked = 0;
      writes = 0;
      dropped_writes = 0;
      pixels = 0;
      border_hits = 0;
    endfunction

    // interleaved bitmap row order: third, pixel line, char row
    function int bitmap_addr(int x, int y);
      int row;
      row = (y & 'hC0) | ((y & 7) << 3) | ((y >> 3) & 7);
      return (row << 5) | (x >> 3);
    endfunction

    function int attr_addr(int x, int y);
      return BITMAP_BYTES + ((y >> 3) << 5) + (x >> 3);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task note_transfer(logic req, logic [12:0] addr, logic [7:0] data,
                       logic signed [9:0] x, logic signed [9:0] y,
                       logic phase, logic [2:0] border);
      int xi;
      int yi;
      logic [7:0] bits;
      logic [7:0] attr;
      logic pix;
      logic [3:0] idx;
      xi = int'(x);
      yi = int'(y);
      if (req == REQ_WRITE) begin
        writes++;
        if (addr < TOTAL_BYTES) screen[addr] = data;
        else dropped_writes++;
        return;
      end
      pixels++;
      if (xi < 0 || yi < 0 || xi >= 256 || yi >= 192) begin
        border_hits++;
        idx = {1'b0, border};
      end else begin
        bits = screen[bitmap_addr(xi, yi)];
        attr = screen[attr_addr(xi, yi)];
        pix = bits[7 - (xi & 7)] ^ (attr[7] & phase);
        idx = {attr[6], pix ? attr[2:0] : attr[5:3]};
      end
      argb_q.push_back(palette[idx]);
      index_q.push_back(idx);
    endtask

    task check_result(logic [31:0] argb_got, logic [3:0] index_got);
      logic [31:0] argb_exp;
      logic [3:0]  index_exp;
      if (argb_q.size() == 0) begin
        report($sformatf("unexpected result argb=%h index=%0d", argb_got, index_got));
        return;
      end
      argb_exp = argb_q.pop_front();
      index_exp = index_q.pop_front();
      checked++;
      if (argb_got !== argb_exp)
        report($sformatf("argb got %h want %h", argb_got, argb_exp));
      if (index_got !== index_exp)
        report($sformatf("color_index got %0d want %0d", index_got, index_exp));
    endtask

    function int pending();
      return argb_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              req_type;
  logic [12:0]       mem_addr;
  logic [7:0]        mem_data;
  logic signed [9:0] pix_x;
  logic signed [9:0] pix_y;
  logic              flash_phase;
  logic [2:0]        border_index;
  logic              strobe;
  logic [31:0]       argb;
  logic [3:0]        color_index;

  pixel_scoreboard sb;
  int cycles;
  int items;
  bit gaps_on;

  attr_bitmap_pixel_fetch_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .mem_addr     (mem_addr),
    .mem_data     (mem_data),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .flash_phase  (flash_phase),
    .border_index (border_index),
    .strobe       (strobe),
    .argb         (argb),
    .color_index  (color_index)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(argb, color_index);
  end

  task automatic send_cmd(logic req, logic [12:0] addr, logic [7:0] data,
                          logic [9:0] x, logic [9:0] y, logic phase, logic [2:0] border);
    start        <= 1'b1;
    req_type     <= req;
    mem_addr     <= addr;
    mem_data     <= data;
    pix_x        <= x;
    pix_y        <= y;
    flash_phase  <= phase;
    border_index <= border;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(req, addr, data, x, y, phase, border);
    items++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic write_byte(int addr, int data);
    send_cmd(REQ_WRITE, addr[12:0], data[7:0], 10'($urandom), 10'($urandom),
             1'($urandom), 3'($urandom));
  endtask

  task automatic read_pixel(int x, int y, int phase, int border);
    send_cmd(REQ_PIXEL, 13'($urandom), 8'($urandom), x[9:0], y[9:0], phase[0], border[2:0]);
  endtask

  task automatic random_phase();
    int kind;
    int x;
    int y;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 191);
      write_byte(sb.bitmap_addr(x, y), $urandom_range(0, 255));
      write_byte(sb.attr_addr(x, y), $urandom_range(0, 255));
      n = $urandom_range(1, 4);
      repeat (n)
        read_pixel((x & ~7) | $urandom_range(0, 7),
                   $urandom_range(0, 1) ? y : (y & ~7) | $urandom_range(0, 7),
                   $urandom_range(0, 1), $urandom_range(0, 7));
    end else if (kind <= 6) begin
      read_pixel($urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                 $urandom_range(0, 1), $urandom_range(0, 7));
    end else if (kind == 7) begin
      write_byte($urandom_range(0, 8191), $urandom_range(0, 255));
    end else if (kind == 8) begin
      read_pixel($urandom_range(0, 255), $urandom_range(0, 191),
                 $urandom_range(0, 1), $urandom_range(0, 7));
    end else begin
      x = $urandom_range(0, 1) ? $urandom_range(0, 1) - 1 : 255 + $urandom_range(0, 1);
      y = $urandom_range(0, 1) ? $urandom_range(0, 1) - 1 : 191 + $urandom_range(0, 1);
      read_pixel(x, y, $urandom_range(0, 1), $urandom_range(0, 7));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    items = 0;
    gaps_on = 1'b0;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_WRITE;
    mem_addr = '0;
    mem_data = '0;
    pix_x = '0;
    pix_y = '0;
    flash_phase = 1'b0;
    border_index = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: cleared memory, flash, bright, corners, dropped writes, border
    read_pixel(0, 0, 0, 0);
    write_byte(0, 'h80);
    write_byte(BITMAP_BYTES, 'hC5);
    read_pixel(0, 0, 0, 7);
    read_pixel(0, 0, 1, 7);
    read_pixel(1, 0, 1, 7);
    write_byte(BITMAP_BYTES - 1, 'hFF);
    write_byte(TOTAL_BYTES - 1, 'h7A);
    read_pixel(255, 191, 0, 0);
    read_pixel(248, 191, 1, 0);
    write_byte(TOTAL_BYTES, 'hFF);
    write_byte(8191, 'hAA);
    read_pixel(-1, 0, 1, 3);
    read_pixel(256, 0, 0, 5);
    read_pixel(0, -1, 0, 6);
    read_pixel(0, 192, 1, 7);
    read_pixel(-512, -512, 0, 1);
    read_pixel(511, 511, 1, 2);
    read_pixel(255, 0, 0, 4);
    read_pixel(0, 191, 1, 0);
    write_byte(0, 'h00);
    read_pixel(0, 0, 1, 0);

    while (items < ITEM_TARGET) begin
      if (items % 100 < 5) gaps_on = ($urandom_range(0, 2) != 0);
      if (items >= ITEM_TARGET - CALM_TAIL) gaps_on = 1'b0;
      random_phase();
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Transfers: %0d writes (%0d beyond memory), %0d pixel requests (%0d border)",
             sb.writes, sb.dropped_writes, sb.pixels, sb.border_hits);
    $display("Results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
